@@ design/mqtt_rd_pkg.sv @@
package mqtt_rd_pkg;

   // Default for the longest remaining-length field accepted (1 to 4 bytes).
   localparam int unsigned MAX_LENGTH_BYTES_DEFAULT = 4;

   // Register reset values.
   localparam logic [15:0] TOPIC_KEEP_RESET   = 16'd127;
   localparam logic [15:0] PAYLOAD_KEEP_RESET = 16'd255;

   // Configuration port geometry: two 32-bit registers at byte addresses 0 and 4.
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;
   localparam logic CSR_TOPIC_KEEP_LIMIT   = 1'b0;
   localparam logic CSR_PAYLOAD_KEEP_LIMIT = 1'b1;

   // Packet type of PUBLISH in the upper nibble of the fixed header.
   localparam logic [3:0] PUBLISH_TYPE = 4'd3;

   // Field widths.
   localparam int unsigned LEN_ACCUM_WIDTH = 28;
   localparam int unsigned LEN_CNT_WIDTH   = 3;

   // Result queue between the parser and the result channel.
   localparam int unsigned QUEUE_DEPTH       = 4;
   localparam int unsigned QUEUE_PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_COUNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      PH_HEADER  = 3'd0,
      PH_LENGTH  = 3'd1,
      PH_TLEN    = 3'd2,
      PH_TOPIC   = 3'd3,
      PH_PID     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_SKIP    = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      KIND_TOPIC       = 3'd0,
      KIND_PAYLOAD     = 3'd1,
      KIND_DONE        = 3'd2,
      KIND_BAD_LENGTH  = 3'd3,
      KIND_BAD_PUBLISH = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
      logic [1:0]  qos_level;
      logic [15:0] packet_ident;
      logic        ack_needed;
      logic [15:0] topic_length;
      logic [15:0] payload_kept;
   } rsp_type;

   // A result that carries only a kind and possibly a data byte.
   function automatic rsp_type make_simple(kind_type kind, logic [7:0] data);
      rsp_type r;
      r              = '0;
      r.kind         = kind;
      r.data_byte    = data;
      return r;
   endfunction

endpackage

@@ design/mqtt_rd_req_if.sv @@
interface mqtt_rd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       restart;

   modport source (output valid, output rx_byte, output restart, input ready);
   modport sink   (input valid, input rx_byte, input restart, output ready);
endinterface

@@ design/mqtt_rd_rsp_if.sv @@
interface mqtt_rd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  data_byte;
   logic [1:0]  qos_level;
   logic [15:0] packet_ident;
   logic        ack_needed;
   logic [15:0] topic_length;
   logic [15:0] payload_kept;

   modport source (output valid, output kind, output data_byte, output qos_level,
                   output packet_ident, output ack_needed, output topic_length,
                   output payload_kept, input ready);
   modport sink   (input valid, input kind, input data_byte, input qos_level,
                   input packet_ident, input ack_needed, input topic_length,
                   input payload_kept, output ready);
endinterface

@@ design/mqtt_receive_deframer_unit.sv @@
// MQTT 3.1.1 receive deframer. The block takes one received stream byte per transaction
// and follows the fixed header, the remaining-length field, and for PUBLISH packets the
// topic length, topic, packet id (QoS above 0) and payload. Each kept topic or payload
// byte leaves as one result transaction, and the last byte of a PUBLISH is followed by a
// done result with QoS, packet id, topic length, kept payload count and the PUBACK flag.
// Malformed length fields and short PUBLISH bodies produce an error result; the rest of
// a short body is skipped. Other packet types produce nothing. A byte is parsed in the
// cycle it is accepted, so one byte is taken every clock; a byte can cause up to two
// results, which go via a four-entry queue that drains one per clock while the receiver
// is ready; the input is held off while fewer than two entries are free. Write the keep
// limits over the APB port only while the stream is idle; the block does not enforce it.
module mqtt_receive_deframer_unit #(
   parameter int unsigned MAX_LENGTH_BYTES = mqtt_rd_pkg::MAX_LENGTH_BYTES_DEFAULT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   mqtt_rd_req_if.sink                             req_if,
   mqtt_rd_rsp_if.source                           rsp_if,
   input  logic                                    csr_psel,
   input  logic                                    csr_penable,
   input  logic                                    csr_pwrite,
   input  logic [mqtt_rd_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  logic [mqtt_rd_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic [mqtt_rd_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                    csr_pready
);
   import mqtt_rd_pkg::*;

   // Parser state.
   phase_type                  phase_ff, phase_in;
   logic [7:0]                 header_ff, header_in;
   logic [LEN_ACCUM_WIDTH-1:0] accum_ff, accum_in;
   logic [LEN_CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [LEN_ACCUM_WIDTH-1:0] body_ff, body_in;
   logic [15:0]                tlen_ff, tlen_in;
   logic [15:0]                seen_ff, seen_in;
   logic [15:0]                pid_ff, pid_in;
   logic [15:0]                pcount_ff, pcount_in;

   // Configuration registers.
   logic [15:0] topic_limit_ff;
   logic [15:0] payload_limit_ff;

   // Result queue.
   rsp_type                      queue_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0]   head_ff, head_in;
   logic [QUEUE_PTR_WIDTH-1:0]   tail_ff, tail_in;
   logic [QUEUE_COUNT_WIDTH-1:0] count_ff, count_in;

   // Shared decode of the current byte.
   logic                       accept;
   logic                       pop;
   logic [7:0]                 b;
   phase_type                  cur_phase;
   logic [1:0]                 qos;
   logic                       has_pid;
   logic                       is_publish;
   logic [LEN_CNT_WIDTH-1:0]   cnt_inc;
   logic [LEN_ACCUM_WIDTH-1:0] len_shifted;
   logic [LEN_ACCUM_WIDTH-1:0] accum_sum;
   logic                       len_overflow;
   logic                       body_empty;
   logic [LEN_ACCUM_WIDTH-1:0] body_dec;
   logic                       body_last;
   logic [15:0]                tlen_full;
   logic [16:0]                tlen_need;
   logic                       tlen_short;
   logic [15:0]                seen_inc;
   logic                       topic_end;
   logic                       topic_keep;
   logic                       payload_keep;

   // Results of the current byte.
   logic    byte_valid;
   rsp_type byte_res;
   logic    term_valid;
   rsp_type term_res;
   rsp_type push0;
   logic [1:0] push_cnt;
   rsp_type head_res;

   assign accept     = req_if.valid && req_if.ready;
   assign pop        = rsp_if.valid && rsp_if.ready;
   assign b          = req_if.rx_byte;
   assign cur_phase  = req_if.restart ? PH_HEADER : phase_ff;
   assign qos        = header_ff[2:1];
   assign has_pid    = (qos != 2'd0);
   assign is_publish = (header_ff[7:4] == PUBLISH_TYPE);

   // Remaining length: seven bits per byte, least significant group first.
   always_comb begin
      unique case (cnt_ff[1:0])
         2'd0:    len_shifted = {21'd0, b[6:0]};
         2'd1:    len_shifted = {14'd0, b[6:0], 7'd0};
         2'd2:    len_shifted = {7'd0, b[6:0], 14'd0};
         default: len_shifted = {b[6:0], 21'd0};
      endcase
   end

   assign cnt_inc      = cnt_ff + 1'b1;
   assign accum_sum    = accum_ff + len_shifted;
   assign len_overflow = b[7] && (cnt_inc >= LEN_CNT_WIDTH'(MAX_LENGTH_BYTES));

   // Body byte bookkeeping.
   assign body_empty   = (body_ff == '0);
   assign body_dec     = body_ff - 1'b1;
   assign body_last    = (body_dec == '0);
   assign tlen_full    = {tlen_ff[15:8], b};
   assign tlen_need    = {1'b0, tlen_full} + (has_pid ? 17'd2 : 17'd0);
   assign tlen_short   = ({11'd0, tlen_need} > body_dec);
   assign seen_inc     = seen_ff + 1'b1;
   assign topic_end    = (seen_inc >= tlen_ff);
   assign topic_keep   = (seen_ff < topic_limit_ff);
   assign payload_keep = (pcount_ff < payload_limit_ff);

   // Next parser state.
   always_comb begin
      phase_in  = phase_ff;
      header_in = header_ff;
      accum_in  = accum_ff;
      cnt_in    = cnt_ff;
      body_in   = body_ff;
      tlen_in   = tlen_ff;
      seen_in   = seen_ff;
      pid_in    = pid_ff;
      pcount_in = pcount_ff;
      unique case (cur_phase)
         PH_HEADER: begin
            header_in = b;
            accum_in  = '0;
            cnt_in    = '0;
            body_in   = '0;
            tlen_in   = '0;
            seen_in   = '0;
            pid_in    = '0;
            pcount_in = '0;
            phase_in  = PH_LENGTH;
         end
         PH_LENGTH: begin
            accum_in = accum_sum;
            cnt_in   = cnt_inc;
            if (b[7]) begin
               phase_in = len_overflow ? PH_HEADER : PH_LENGTH;
            end else begin
               body_in = accum_sum;
               cnt_in  = '0;
               if (accum_sum == '0) begin
                  phase_in = PH_HEADER;
               end else begin
                  phase_in = is_publish ? PH_TLEN : PH_SKIP;
               end
            end
         end
         default: begin
            if (body_empty) begin
               phase_in = PH_HEADER;
            end else begin
               body_in = body_dec;
               unique case (cur_phase)
                  PH_TLEN: begin
                     if (cnt_ff == '0) begin
                        tlen_in  = {b, 8'h00};
                        cnt_in   = LEN_CNT_WIDTH'(1);
                        if (body_last) begin
                           phase_in = PH_HEADER;
                        end
                     end else begin
                        tlen_in = tlen_full;
                        seen_in = '0;
                        if (tlen_short) begin
                           phase_in = body_last ? PH_HEADER : PH_SKIP;
                        end else if (tlen_full != 16'd0) begin
                           phase_in = PH_TOPIC;
                        end else if (has_pid) begin
                           phase_in = PH_PID;
                           cnt_in   = '0;
                        end else begin
                           phase_in = body_last ? PH_HEADER : PH_PAYLOAD;
                        end
                     end
                  end
                  PH_TOPIC: begin
                     seen_in = seen_inc;
                     if (topic_end) begin
                        if (has_pid) begin
                           phase_in = PH_PID;
                           cnt_in   = '0;
                        end else begin
                           phase_in = body_last ? PH_HEADER : PH_PAYLOAD;
                        end
                     end
                  end
                  PH_PID: begin
                     if (cnt_ff == '0) begin
                        pid_in = {b, 8'h00};
                        cnt_in = LEN_CNT_WIDTH'(1);
                     end else begin
                        pid_in   = {pid_ff[15:8], b};
                        phase_in = body_last ? PH_HEADER : PH_PAYLOAD;
                     end
                  end
                  PH_PAYLOAD: begin
                     if (payload_keep) begin
                        pcount_in = pcount_ff + 1'b1;
                     end
                     if (body_last) begin
                        phase_in = PH_HEADER;
                     end
                  end
                  default: begin
                     if (body_last) begin
                        phase_in = PH_HEADER;
                     end
                  end
               endcase
            end
         end
      endcase
   end

   // Results of the current byte: an optional data byte, then an optional
   // done or error result.
   always_comb begin
      byte_valid             = 1'b0;
      byte_res               = make_simple(KIND_TOPIC, b);
      term_valid             = 1'b0;
      term_res               = make_simple(KIND_DONE, 8'h00);
      term_res.qos_level     = qos;
      term_res.packet_ident  = has_pid ? pid_in : 16'd0;
      term_res.ack_needed    = (qos == 2'd1);
      term_res.topic_length  = tlen_in;
      term_res.payload_kept  = pcount_in;
      unique case (cur_phase)
         PH_HEADER: begin
         end
         PH_LENGTH: begin
            if (len_overflow) begin
               term_valid = 1'b1;
               term_res   = make_simple(KIND_BAD_LENGTH, 8'h00);
            end else if (!b[7] && is_publish && (accum_sum == '0)) begin
               term_valid = 1'b1;
               term_res   = make_simple(KIND_BAD_PUBLISH, 8'h00);
            end
         end
         default: begin
            if (!body_empty) begin
               unique case (cur_phase)
                  PH_TLEN: begin
                     if (cnt_ff == '0) begin
                        if (body_last) begin
                           term_valid = 1'b1;
                           term_res   = make_simple(KIND_BAD_PUBLISH, 8'h00);
                        end
                     end else if (tlen_short) begin
                        term_valid = 1'b1;
                        term_res   = make_simple(KIND_BAD_PUBLISH, 8'h00);
                     end else if ((tlen_full == 16'd0) && !has_pid && body_last) begin
                        term_valid = 1'b1;
                     end
                  end
                  PH_TOPIC: begin
                     byte_valid = topic_keep;
                     term_valid = topic_end && !has_pid && body_last;
                  end
                  PH_PID: begin
                     term_valid = (cnt_ff != '0) && body_last;
                  end
                  PH_PAYLOAD: begin
                     byte_valid = payload_keep;
                     byte_res   = make_simple(KIND_PAYLOAD, b);
                     term_valid = body_last;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
   end

   // Queue write side: results are packed into consecutive entries.
   assign push0    = byte_valid ? byte_res : term_res;
   assign push_cnt = accept ? ({1'b0, byte_valid} + {1'b0, term_valid}) : 2'd0;

   // Queue pointers and fill count.
   always_comb begin
      tail_in  = tail_ff + QUEUE_PTR_WIDTH'(push_cnt);
      head_in  = pop ? head_ff + 1'b1 : head_ff;
      count_in = count_ff + QUEUE_COUNT_WIDTH'(push_cnt)
                 - (pop ? QUEUE_COUNT_WIDTH'(1) : QUEUE_COUNT_WIDTH'(0));
   end

   // Take a byte only while two queue entries are free.
   assign req_if.ready = (count_ff <= QUEUE_COUNT_WIDTH'(QUEUE_DEPTH - 2));

   // Result channel is driven from the queue head.
   assign head_res            = queue_ff[head_ff];
   assign rsp_if.valid        = (count_ff != '0);
   assign rsp_if.kind         = head_res.kind;
   assign rsp_if.data_byte    = head_res.data_byte;
   assign rsp_if.qos_level    = head_res.qos_level;
   assign rsp_if.packet_ident = head_res.packet_ident;
   assign rsp_if.ack_needed   = head_res.ack_needed;
   assign rsp_if.topic_length = head_res.topic_length;
   assign rsp_if.payload_kept = head_res.payload_kept;

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         queue_ff[tail_ff] <= push0;
      end
      if (push_cnt == 2'd2) begin
         queue_ff[tail_ff + 1'b1] <= term_res;
      end
   end

   // Queue control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Parser registers advance on each accepted byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         header_ff <= '0;
         accum_ff  <= '0;
         cnt_ff    <= '0;
         body_ff   <= '0;
         tlen_ff   <= '0;
         seen_ff   <= '0;
         pid_ff    <= '0;
         pcount_ff <= '0;
      end else if (accept) begin
         phase_ff  <= phase_in;
         header_ff <= header_in;
         accum_ff  <= accum_in;
         cnt_ff    <= cnt_in;
         body_ff   <= body_in;
         tlen_ff   <= tlen_in;
         seen_ff   <= seen_in;
         pid_ff    <= pid_in;
         pcount_ff <= pcount_in;
      end
   end

   // Configuration register writes on the APB access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         topic_limit_ff   <= TOPIC_KEEP_RESET;
         payload_limit_ff <= PAYLOAD_KEEP_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
         unique case (csr_paddr[2])
            CSR_TOPIC_KEEP_LIMIT:   topic_limit_ff   <= csr_pwdata[15:0];
            CSR_PAYLOAD_KEEP_LIMIT: payload_limit_ff <= csr_pwdata[15:0];
         endcase
      end
   end

   // Register read back.
   assign csr_pready = 1'b1;
   always_comb begin
      unique case (csr_paddr[2])
         CSR_TOPIC_KEEP_LIMIT:   csr_prdata = {16'd0, topic_limit_ff};
         CSR_PAYLOAD_KEEP_LIMIT: csr_prdata = {16'd0, payload_limit_ff};
      endcase
   end

endmodule

@@ bench/mqtt_receive_deframer_unit_test.sv @@
module mqtt_receive_deframer_unit_test;
   import mqtt_rd_pkg::*;

   localparam int unsigned LEN_FIELD_MAX = MAX_LENGTH_BYTES_DEFAULT;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned PRINT_LIMIT   = 40;

   localparam logic [CSR_ADDR_WIDTH-1:0] TOPIC_KEEP_ADDR   = {CSR_TOPIC_KEEP_LIMIT, 2'b00};
   localparam logic [CSR_ADDR_WIDTH-1:0] PAYLOAD_KEEP_ADDR = {CSR_PAYLOAD_KEEP_LIMIT, 2'b00};

   typedef struct packed {
      logic       restart;
      logic [7:0] value;
   } stream_byte_type;

   logic clock;
   logic reset;

   logic                      csr_psel;
   logic                      csr_penable;
   logic                      csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic                      csr_pready;

   mqtt_rd_req_if req_chan ();
   mqtt_rd_rsp_if rsp_chan ();

   mqtt_receive_deframer_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_chan),
      .rsp_if      (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Byte stream waiting to be sent, and the parser events it must produce.
   stream_byte_type rx_stream [$];
   rsp_type         events_due [$];

   int unsigned src_gap_max;
   int unsigned sink_stall_max;
   int unsigned src_gap;
   int unsigned sink_stall;
   int unsigned mismatch_count;
   int unsigned results_seen;
   int unsigned cycle_count;
   stream_byte_type next_byte;

   // Shadow of the parser state and of the keep limits.
   phase_type   frame_phase;
   logic [7:0]  hdr_byte;
   logic [27:0] len_accum;
   logic [2:0]  field_cnt;
   logic [27:0] body_left;
   logic [15:0] topic_len;
   logic [15:0] topic_seen;
   logic [15:0] pid_reg;
   logic [15:0] payload_cnt;
   logic [15:0] topic_keep;
   logic [15:0] payload_keep;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic void emit_event(kind_type k, logic [7:0] data = 8'h00,
                                      logic [1:0] qos = 2'd0, logic [15:0] id = 16'h0000,
                                      logic ack = 1'b0, logic [15:0] tlen = 16'h0000,
                                      logic [15:0] kept = 16'h0000);
      rsp_type ev;
      ev.kind         = k;
      ev.data_byte    = data;
      ev.qos_level    = qos;
      ev.packet_ident = id;
      ev.ack_needed   = ack;
      ev.topic_length = tlen;
      ev.payload_kept = kept;
      events_due.push_back(ev);
   endfunction

   function automatic void publish_done();
      logic [1:0] q;
      q = hdr_byte[2:1];
      frame_phase = PH_HEADER;
      emit_event(KIND_DONE, 8'h00, q, (q != 2'd0) ? pid_reg : 16'h0000, q == 2'd1,
                 topic_len, payload_cnt);
   endfunction

   function automatic void after_packet_id();
      if (body_left != 0) begin
         frame_phase = PH_PAYLOAD;
      end else begin
         publish_done();
      end
   endfunction

   // QoS 1 and above (QoS 3 behaves as 2) carry a packet id after the topic.
   function automatic void after_topic_bytes();
      if (hdr_byte[2:1] != 2'd0) begin
         frame_phase = PH_PID;
         field_cnt = 3'd0;
      end else begin
         after_packet_id();
      end
   endfunction

   function automatic void reject_publish();
      frame_phase = (body_left != 0) ? PH_SKIP : PH_HEADER;
      emit_event(KIND_BAD_PUBLISH);
   endfunction

   // Advances the shadow parser by one stream byte and queues the events it causes.
   function automatic void deframe_byte(logic [7:0] b, logic restart);
      int unsigned shift;
      int unsigned need;
      if (restart)
         frame_phase = PH_HEADER;
      if (frame_phase == PH_HEADER) begin
         hdr_byte    = b;
         len_accum   = '0;
         field_cnt   = '0;
         body_left   = '0;
         topic_len   = '0;
         topic_seen  = '0;
         pid_reg     = '0;
         payload_cnt = '0;
         frame_phase = PH_LENGTH;
      end else if (frame_phase == PH_LENGTH) begin
         // Seven bits per length byte, least significant group first.
         shift = 7 * field_cnt[1:0];
         len_accum = len_accum + (28'(b[6:0]) << shift);
         field_cnt = field_cnt + 3'd1;
         if (b[7]) begin
            if (field_cnt >= LEN_FIELD_MAX) begin
               frame_phase = PH_HEADER;
               emit_event(KIND_BAD_LENGTH);
            end
         end else begin
            body_left = len_accum;
            field_cnt = 3'd0;
            if (hdr_byte[7:4] == PUBLISH_TYPE) begin
               if (body_left == 0)
                  reject_publish();
               else
                  frame_phase = PH_TLEN;
            end else begin
               frame_phase = (body_left != 0) ? PH_SKIP : PH_HEADER;
            end
         end
      end else if (body_left == 0) begin
         frame_phase = PH_HEADER;
      end else begin
         body_left = body_left - 28'd1;
         case (frame_phase)
            PH_TLEN: begin
               if (field_cnt == 3'd0) begin
                  topic_len = {b, 8'h00};
                  field_cnt = 3'd1;
                  if (body_left == 0)
                     reject_publish();
               end else begin
                  topic_len = topic_len | {8'h00, b};
                  topic_seen = '0;
                  need = topic_len + ((hdr_byte[2:1] != 2'd0) ? 2 : 0);
                  if (need > body_left)
                     reject_publish();
                  else if (topic_len != 0)
                     frame_phase = PH_TOPIC;
                  else
                     after_topic_bytes();
               end
            end
            PH_TOPIC: begin
               if (topic_seen < topic_keep)
                  emit_event(KIND_TOPIC, b);
               topic_seen = topic_seen + 16'd1;
               if (topic_seen >= topic_len)
                  after_topic_bytes();
            end
            PH_PID: begin
               if (field_cnt == 3'd0) begin
                  pid_reg = {b, 8'h00};
                  field_cnt = 3'd1;
               end else begin
                  pid_reg = pid_reg | {8'h00, b};
                  after_packet_id();
               end
            end
            PH_PAYLOAD: begin
               if (payload_cnt < payload_keep) begin
                  emit_event(KIND_PAYLOAD, b);
                  payload_cnt = payload_cnt + 16'd1;
               end
               if (body_left == 0)
                  publish_done();
            end
            default: begin
               if (body_left == 0)
                  frame_phase = PH_HEADER;
            end
         endcase
      end
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("[%0t] result %0d, %s: got 0x%0h, expected 0x%0h",
                  $time, results_seen, what, got, want);
   endtask

   task automatic compare_event();
      rsp_type want;
      if (events_due.size() == 0) begin
         report_mismatch("no event expected, kind", 32'(rsp_chan.kind), 32'd0);
      end else begin
         want = events_due.pop_front();
         if (rsp_chan.kind != want.kind)
            report_mismatch("kind", 32'(rsp_chan.kind), 32'(want.kind));
         if (rsp_chan.data_byte != want.data_byte)
            report_mismatch("data_byte", 32'(rsp_chan.data_byte), 32'(want.data_byte));
         if (rsp_chan.qos_level != want.qos_level)
            report_mismatch("qos_level", 32'(rsp_chan.qos_level), 32'(want.qos_level));
         if (rsp_chan.packet_ident != want.packet_ident)
            report_mismatch("packet_ident", 32'(rsp_chan.packet_ident),
                            32'(want.packet_ident));
         if (rsp_chan.ack_needed != want.ack_needed)
            report_mismatch("ack_needed", 32'(rsp_chan.ack_needed), 32'(want.ack_needed));
         if (rsp_chan.topic_length != want.topic_length)
            report_mismatch("topic_length", 32'(rsp_chan.topic_length),
                            32'(want.topic_length));
         if (rsp_chan.payload_kept != want.payload_kept)
            report_mismatch("payload_kept", 32'(rsp_chan.payload_kept),
                            32'(want.payload_kept));
      end
      results_seen++;
   endtask

   // Sender: each accepted transaction updates the shadow parser, then a new byte
   // goes out after a random gap.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         src_gap = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            deframe_byte(req_chan.rx_byte, req_chan.restart);
         if (!req_chan.valid || req_chan.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_chan.valid <= 1'b0;
            end else if (rx_stream.size() != 0) begin
               next_byte = rx_stream.pop_front();
               req_chan.valid   <= 1'b1;
               req_chan.rx_byte <= next_byte.value;
               req_chan.restart <= next_byte.restart;
               src_gap = $urandom_range(0, src_gap_max);
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each result transaction, then stalls for a random time.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         sink_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            compare_event();
            sink_stall = $urandom_range(0, sink_stall_max);
         end
         if (sink_stall > 0) begin
            sink_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic void queue_byte(logic [7:0] value, logic restart);
      stream_byte_type sb;
      sb.value   = value;
      sb.restart = restart;
      rx_stream.push_back(sb);
   endfunction

   // Remaining-length field, padded with empty continuation groups up to min_bytes.
   function automatic void queue_length(int unsigned value, int unsigned min_bytes);
      int unsigned rest;
      int unsigned used;
      logic more;
      rest = value;
      used = 0;
      do begin
         used++;
         more = ((rest >> 7) != 0) || (used < min_bytes);
         queue_byte({more, rest[6:0]}, 1'b0);
         rest = rest >> 7;
      end while (more);
   endfunction

   function automatic logic [7:0] publish_header(logic [1:0] qos);
      return {PUBLISH_TYPE, 1'($urandom), qos, 1'($urandom)};
   endfunction

   function automatic void queue_publish(logic [1:0] qos, int unsigned topic_n,
                                         int unsigned payload_n, logic restart);
      int unsigned body;
      body = 2 + topic_n + payload_n + ((qos != 2'd0) ? 2 : 0);
      queue_byte(publish_header(qos), restart);
      queue_length(body, ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1);
      queue_byte(topic_n[15:8], 1'b0);
      queue_byte(topic_n[7:0], 1'b0);
      repeat (topic_n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
      if (qos != 2'd0) begin
         queue_byte(8'($urandom_range(0, 255)), 1'b0);
         queue_byte(8'($urandom_range(0, 255)), 1'b0);
      end
      repeat (payload_n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
   endfunction

   // Mostly well-formed PUBLISH packets, with other packet types, malformed
   // packets and line noise mixed in. A restart follows anything that leaves
   // the parser mid-packet, except at the end of a call.
   function automatic void queue_traffic(int unsigned count);
      int unsigned start;
      int unsigned pick;
      int unsigned n;
      int unsigned want;
      logic [1:0] qos;
      logic [7:0] hdr;
      logic resync;
      logic rs;
      start = rx_stream.size();
      resync = 1'b0;
      while (rx_stream.size() - start < count) begin
         pick = $urandom_range(0, 19);
         qos = 2'($urandom_range(0, 3));
         rs = resync || ($urandom_range(0, 7) == 0);
         resync = 1'b0;
         if (pick < 12) begin
            queue_publish(qos, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 6),
                          $urandom_range(0, 8), rs);
         end else if (pick < 14) begin
            // Another packet type, skipped without output.
            hdr = 8'($urandom_range(0, 255));
            if (hdr[7:4] == PUBLISH_TYPE)
               hdr[7] = 1'b1;
            n = $urandom_range(0, 5);
            queue_byte(hdr, rs);
            queue_length(n, 1);
            repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick == 14) begin
            // Length field that never ends.
            queue_byte(8'($urandom_range(0, 255)), rs);
            repeat (LEN_FIELD_MAX) queue_byte(8'h80 | 8'($urandom_range(0, 255)), 1'b0);
         end else if (pick == 15) begin
            // Body ends inside the topic length.
            queue_byte(publish_header(qos), rs);
            queue_length(1, 1);
            queue_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick == 16) begin
            // Declared topic does not fit in the body.
            n = $urandom_range(0, 5);
            want = n + 1 + $urandom_range(0, 299);
            queue_byte(publish_header(qos), rs);
            queue_length(n + 2, 1);
            queue_byte(want[15:8], 1'b0);
            queue_byte(want[7:0], 1'b0);
            repeat (n) queue_byte(8'($urandom_range(0, 255)), 1'b0);
         end else if (pick == 17) begin
            // Publish cut short; the next packet restarts the parser.
            queue_byte(publish_header(qos), rs);
            queue_length(12, 1);
            repeat ($urandom_range(0, 6)) queue_byte(8'($urandom_range(0, 255)), 1'b0);
            resync = 1'b1;
         end else if (pick == 18) begin
            repeat ($urandom_range(1, 3))
               queue_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            resync = 1'b1;
         end else begin
            queue_publish(qos, $urandom_range(0, 40), $urandom_range(0, 40), rs);
         end
      end
   endfunction

   task automatic csr_write(logic [CSR_ADDR_WIDTH-1:0] addr, logic [CSR_DATA_WIDTH-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_keep_limits(logic [15:0] topic_lim, logic [15:0] payload_lim);
      csr_write(TOPIC_KEEP_ADDR, {16'h0000, topic_lim});
      csr_write(PAYLOAD_KEEP_ADDR, {16'h0000, payload_lim});
      topic_keep   = topic_lim;
      payload_keep = payload_lim;
      @(negedge clock);
   endtask

   // Waits until every byte is sent and every event has arrived, then idles before returning.
   task automatic settle();
      do @(negedge clock);
      while (rx_stream.size() != 0 || req_chan.valid || events_due.size() != 0);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      logic [8:0] opening [$];
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.rx_byte = 8'h00;
      req_chan.restart = 1'b0;
      rsp_chan.ready   = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = '0;
      mismatch_count   = 0;
      results_seen     = 0;
      cycle_count      = 0;
      src_gap_max      = 5;
      sink_stall_max   = 5;
      frame_phase      = PH_HEADER;
      hdr_byte         = '0;
      len_accum        = '0;
      field_cnt        = '0;
      body_left        = '0;
      topic_len        = '0;
      topic_seen       = '0;
      pid_reg          = '0;
      payload_cnt      = '0;
      topic_keep       = TOPIC_KEEP_RESET;
      payload_keep     = PAYLOAD_KEEP_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed bytes; bit 8 is the restart flag.
      opening = '{
         // Restart on a header, then a length field with four continuation bytes.
         9'h130, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
         // QoS 3, empty topic and empty payload.
         9'h036, 9'h004, 9'h000, 9'h000, 9'h0FF, 9'h0FF,
         // QoS 1 with one topic byte and one payload byte.
         9'h032, 9'h006, 9'h000, 9'h001, 9'h0FF, 9'h012, 9'h034, 9'h000,
         // Publish with an empty body.
         9'h030, 9'h000,
         // Body ends inside the topic length.
         9'h03B, 9'h001, 9'h000,
         // Partial publish dropped by a restart into an empty non-publish packet.
         9'h030, 9'h005, 9'h000, 9'h1C0, 9'h000,
         // Topic too long for the body; the rest of the body is skipped.
         9'h034, 9'h005, 9'h000, 9'h004, 9'h0AA, 9'h055, 9'h0CC
      };
      foreach (opening[i])
         queue_byte(opening[i][7:0], opening[i][8]);
      settle();

      // Reset limits, with one packet whose topic runs past the topic limit.
      queue_publish(2'd1, 130, 6, 1'b0);
      queue_traffic(25);
      settle();

      // Nothing kept, no idling on either side.
      program_keep_limits(16'h0000, 16'h0000);
      src_gap_max    = 0;
      sink_stall_max = 0;
      queue_traffic(30);
      settle();

      // Everything kept; the sender also pauses mid-phase until all events are in.
      program_keep_limits(16'hFFFF, 16'hFFFF);
      src_gap_max    = 5;
      sink_stall_max = 0;
      queue_traffic(15);
      settle();
      queue_traffic(15);
      settle();

      program_keep_limits(16'd2, 16'd3);
      src_gap_max    = 0;
      sink_stall_max = 5;
      queue_traffic(30);
      settle();

      program_keep_limits(16'($urandom_range(0, 8)), 16'($urandom_range(0, 8)));
      src_gap_max    = 5;
      sink_stall_max = 5;
      queue_traffic(30);
      settle();

      program_keep_limits(TOPIC_KEEP_RESET, 16'd1);
      queue_traffic(20);
      settle();

      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
